// ===== design/v3alu_pkg.sv =====
// ----------------------------------------------------------------------------
// v3alu_pkg: shared types and constants for the 3-vector fixed-point ALU
// Word structs, operation codes, widths and the saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package v3alu_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;
	localparam int FIELD_W   = 32;
	localparam int LANES     = 3;
	localparam int WIDE_W    = 2 * FIELD_W + 2;

	// integer square root: 64-bit radicand, 32-bit root
	localparam int RAD_W   = 2 * FIELD_W;
	localparam int ROOT_W  = FIELD_W;
	// divider: |n| << FRAC_BITS over a 32-bit magnitude
	localparam int DIV_N_W = FIELD_W + FRAC_BITS;
	localparam int DIV_D_W = FIELD_W;

	localparam logic signed [WIDE_W-1:0] FX_MAX =
		(WIDE_W'(1) <<< (WORD_BITS - 1)) - WIDE_W'(1);
	localparam logic signed [WIDE_W-1:0] FX_MIN = -FX_MAX - WIDE_W'(1);

	localparam logic [3:0] OP_ADD   = 4'd0;
	localparam logic [3:0] OP_SUB   = 4'd1;
	localparam logic [3:0] OP_EMUL  = 4'd2;
	localparam logic [3:0] OP_EDIV  = 4'd3;
	localparam logic [3:0] OP_ADDS  = 4'd4;
	localparam logic [3:0] OP_SUBS  = 4'd5;
	localparam logic [3:0] OP_MULS  = 4'd6;
	localparam logic [3:0] OP_DIVS  = 4'd7;
	localparam logic [3:0] OP_SMINV = 4'd8;
	localparam logic [3:0] OP_SDIVV = 4'd9;
	localparam logic [3:0] OP_NEG   = 4'd10;
	localparam logic [3:0] OP_CROSS = 4'd11;
	localparam logic [3:0] OP_DOT   = 4'd12;
	localparam logic [3:0] OP_NORM  = 4'd13;
	localparam logic [3:0] OP_UNIT  = 4'd14;

	typedef logic signed [FIELD_W-1:0] fx_t;

	typedef struct packed {
		logic [3:0] kind;
		fx_t        a_x;
		fx_t        a_y;
		fx_t        a_z;
		fx_t        b_x;
		fx_t        b_y;
		fx_t        b_z;
		fx_t        scalar;
	} cmd_t;

	typedef struct packed {
		fx_t  res_x;
		fx_t  res_y;
		fx_t  res_z;
		fx_t  res_scalar;
		logic saturated;
		logic div_zero;
	} rsp_t;

	// sideband riding along the square-root pipeline
	typedef struct packed {
		logic [3:0]                kind;
		logic [LANES-1:0][FIELD_W-1:0] num;
		logic [LANES-1:0][FIELD_W-1:0] den;
		logic [LANES-1:0][FIELD_W-1:0] r;
		logic [FIELD_W-1:0]        rs;
		logic                      sat;
	} sq_side_t;

	// sideband riding along the divider pipeline
	typedef struct packed {
		logic [3:0]                kind;
		logic [LANES-1:0][FIELD_W-1:0] num;
		logic [LANES-1:0]          neg;
		logic [LANES-1:0]          dzero;
		logic [LANES-1:0][FIELD_W-1:0] r;
		logic [FIELD_W-1:0]        rs;
		logic                      sat;
	} dv_side_t;

	typedef struct packed {
		fx_t  val;
		logic clip;
	} sat_t;

	function automatic sat_t sat_fx(input logic signed [WIDE_W-1:0] v);
		sat_t o;
		if (v > FX_MAX) begin
			o.val  = FX_MAX[FIELD_W-1:0];
			o.clip = 1'b1;
		end else if (v < FX_MIN) begin
			o.val  = FX_MIN[FIELD_W-1:0];
			o.clip = 1'b1;
		end else begin
			o.val  = v[FIELD_W-1:0];
			o.clip = 1'b0;
		end
		return o;
	endfunction

endpackage

`default_nettype wire

// ===== design/v3alu_sqrt.sv =====
// ----------------------------------------------------------------------------
// v3alu_sqrt: pipelined integer square root
// One root bit per stage, floor result, sideband word carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module v3alu_sqrt
	import v3alu_pkg::*;
#(
	parameter type side_t = sq_side_t
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire side_t            in_side,
	input  wire logic [RAD_W-1:0] radicand,
	output logic                  out_valid,
	output side_t                 out_side,
	output logic [ROOT_W-1:0]     root
);

	localparam int ST    = ROOT_W;
	localparam int REM_W = ROOT_W + 3;

	logic              v_s    [0:ST];
	side_t             side_s [0:ST];
	logic [RAD_W-1:0]  rad_s  [0:ST];
	logic [REM_W-1:0]  rem_s  [0:ST];
	logic [ROOT_W-1:0] root_s [0:ST];

	assign v_s[0]    = in_valid;
	assign side_s[0] = in_side;
	assign rad_s[0]  = radicand;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar k = 0; k < ST; k++) begin : g_st
		logic [REM_W-1:0] t;
		logic [REM_W-1:0] trial;
		logic             ge;

		always_comb begin
			t     = {rem_s[k][REM_W-3:0], rad_s[k][RAD_W-1 -: 2]};
			trial = {1'b0, root_s[k], 2'b01};
			ge    = (t >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
			rad_s[k+1]  <= rad_s[k] << 2;
			rem_s[k+1]  <= ge ? (t - trial) : t;
			root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
		end
	end

	assign out_valid = v_s[ST];
	assign out_side  = side_s[ST];
	assign root      = root_s[ST];

endmodule

`default_nettype wire

// ===== design/v3alu_div.sv =====
// ----------------------------------------------------------------------------
// v3alu_div: three-lane pipelined unsigned divider
// Restoring division, one quotient bit per stage, sideband carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module v3alu_div
	import v3alu_pkg::*;
#(
	parameter type side_t = dv_side_t
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	input  wire side_t                            in_side,
	input  wire logic [LANES-1:0][DIV_N_W-1:0]    dividend,
	input  wire logic [LANES-1:0][DIV_D_W-1:0]    divisor,
	output logic                                  out_valid,
	output side_t                                 out_side,
	output logic [LANES-1:0][DIV_N_W-1:0]         quotient
);

	localparam int ST = DIV_N_W;

	logic                             v_s    [0:ST];
	side_t                            side_s [0:ST];
	logic [LANES-1:0][DIV_N_W-1:0]    n_s    [0:ST];
	logic [LANES-1:0][DIV_D_W-1:0]    d_s    [0:ST];
	logic [LANES-1:0][DIV_D_W-1:0]    rem_s  [0:ST];
	logic [LANES-1:0][DIV_N_W-1:0]    q_s    [0:ST];

	assign v_s[0]    = in_valid;
	assign side_s[0] = in_side;
	assign n_s[0]    = dividend;
	assign d_s[0]    = divisor;
	assign rem_s[0]  = '0;
	assign q_s[0]    = '0;

	for (genvar k = 0; k < ST; k++) begin : g_st
		logic [LANES-1:0][DIV_D_W-1:0] rem_nx;
		logic [LANES-1:0]              qbit;

		always_comb begin
			for (int i = 0; i < LANES; i++) begin
				logic [DIV_D_W:0] t;
				t = {rem_s[k][i], n_s[k][i][DIV_N_W-1]};
				qbit[i]   = (t >= {1'b0, d_s[k][i]});
				rem_nx[i] = qbit[i] ? DIV_D_W'(t - {1'b0, d_s[k][i]}) : t[DIV_D_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
			d_s[k+1]    <= d_s[k];
			rem_s[k+1]  <= rem_nx;
			for (int i = 0; i < LANES; i++) begin
				n_s[k+1][i] <= n_s[k][i] << 1;
				q_s[k+1][i] <= {q_s[k][i][DIV_N_W-2:0], qbit[i]};
			end
		end
	end

	assign out_valid = v_s[ST];
	assign out_side  = side_s[ST];
	assign quotient  = q_s[ST];

endmodule

`default_nettype wire

// ===== design/vector3_fixed_point_alu.sv =====
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu: pipelined 3-vector ALU, signed Q16.16
// Elementwise, scalar, cross, dot, norm and unit operations with saturation.
// ----------------------------------------------------------------------------
// Takes one command word per clock, every clock: busy is never raised. Each
// word comes back as one result word, strobed by done for a single cycle,
// in order. Every operation takes the same path: 3 front stages (operand
// register, multipliers, sums and saturation), 32 square-root stages (one
// root bit each), one divider setup stage, 48 divider stages (one quotient
// bit each) and the output register.
// The receiver cannot stall; results must be taken on the done cycle.
// Division by zero returns the signed extreme with div_zero and saturated
// set; unit of a zero vector returns b unchanged with no flags.
`default_nettype none

module vector3_fixed_point_alu
	import v3alu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire cmd_t operands,
	output logic      done,
	output rsp_t      result
);

	localparam int LAT = 3 + ROOT_W + 1 + DIV_N_W + 1;

	// never stalls
	assign busy = 1'b0;

	// ---- stage 1: operand register
	logic v_s1;
	cmd_t cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= operands;
	end

	// ---- stage 2: products (two multipliers per lane)
	fx_t a1 [LANES];
	fx_t b1 [LANES];
	fx_t m0a [LANES];
	fx_t m0b [LANES];
	fx_t m1a [LANES];
	fx_t m1b [LANES];

	always_comb begin
		a1[0] = cmd_s1.a_x; a1[1] = cmd_s1.a_y; a1[2] = cmd_s1.a_z;
		b1[0] = cmd_s1.b_x; b1[1] = cmd_s1.b_y; b1[2] = cmd_s1.b_z;
		for (int i = 0; i < LANES; i++) begin
			m0a[i] = a1[i];
			m0b[i] = b1[i];
			m1a[i] = '0;
			m1b[i] = '0;
			case (cmd_s1.kind)
				OP_MULS: begin
					m0b[i] = cmd_s1.scalar;
				end
				OP_NORM, OP_UNIT: begin
					m0a[i] = b1[i];
				end
				OP_CROSS: begin
					m0a[i] = a1[(i + 1) % LANES];
					m0b[i] = b1[(i + 2) % LANES];
					m1a[i] = a1[(i + 2) % LANES];
					m1b[i] = b1[(i + 1) % LANES];
				end
				default: begin
				end
			endcase
		end
	end

	logic                        v_s2;
	cmd_t                        cmd_s2;
	logic signed [RAD_W-1:0]     p0_s2 [LANES];
	logic signed [RAD_W-1:0]     p1_s2 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2 <= cmd_s1;
		for (int i = 0; i < LANES; i++) begin
			p0_s2[i] <= m0a[i] * m0b[i];
			p1_s2[i] <= m1a[i] * m1b[i];
		end
	end

	// ---- stage 3: sums, floor shift, saturation; divider operands
	fx_t                      a2 [LANES];
	fx_t                      b2 [LANES];
	fx_t                      s2;
	logic signed [WIDE_W-1:0] wide [LANES];
	logic signed [WIDE_W-1:0] dot_w;
	sat_t                     lane_sat [LANES];
	sat_t                     rs_sat;
	sq_side_t                 side3;
	logic [RAD_W-1:0]         rad3;

	always_comb begin
		a2[0] = cmd_s2.a_x; a2[1] = cmd_s2.a_y; a2[2] = cmd_s2.a_z;
		b2[0] = cmd_s2.b_x; b2[1] = cmd_s2.b_y; b2[2] = cmd_s2.b_z;
		s2    = cmd_s2.scalar;
		side3 = '0;
		side3.kind = cmd_s2.kind;
		dot_w = '0;
		rad3  = '0;
		for (int i = 0; i < LANES; i++) begin
			case (cmd_s2.kind)
				OP_ADD:   wide[i] = WIDE_W'(a2[i]) + WIDE_W'(b2[i]);
				OP_SUB:   wide[i] = WIDE_W'(a2[i]) - WIDE_W'(b2[i]);
				OP_ADDS:  wide[i] = WIDE_W'(a2[i]) + WIDE_W'(s2);
				OP_SUBS:  wide[i] = WIDE_W'(a2[i]) - WIDE_W'(s2);
				OP_SMINV: wide[i] = WIDE_W'(s2) - WIDE_W'(b2[i]);
				OP_NEG:   wide[i] = -WIDE_W'(b2[i]);
				OP_EMUL, OP_MULS: wide[i] = WIDE_W'(p0_s2[i]) >>> FRAC_BITS;
				OP_CROSS: wide[i] = (WIDE_W'(p0_s2[i]) - WIDE_W'(p1_s2[i])) >>> FRAC_BITS;
				default:  wide[i] = '0;
			endcase
			lane_sat[i] = sat_fx(wide[i]);
			side3.r[i]  = lane_sat[i].val;
			case (cmd_s2.kind)
				OP_EDIV: begin
					side3.num[i] = a2[i];
					side3.den[i] = b2[i];
				end
				OP_DIVS: begin
					side3.num[i] = a2[i];
					side3.den[i] = s2;
				end
				OP_SDIVV: begin
					side3.num[i] = s2;
					side3.den[i] = b2[i];
				end
				OP_UNIT: begin
					side3.num[i] = b2[i];
				end
				default: begin
				end
			endcase
		end
		if (cmd_s2.kind == OP_DOT) begin
			dot_w = (WIDE_W'(p0_s2[0]) + WIDE_W'(p0_s2[1]) + WIDE_W'(p0_s2[2])) >>> FRAC_BITS;
		end
		if (cmd_s2.kind inside {OP_NORM, OP_UNIT}) begin
			// squares are non-negative and their sum stays below 2^64
			rad3 = RAD_W'(p0_s2[0]) + RAD_W'(p0_s2[1]) + RAD_W'(p0_s2[2]);
		end
		rs_sat    = sat_fx(dot_w);
		side3.rs  = rs_sat.val;
		side3.sat = lane_sat[0].clip | lane_sat[1].clip | lane_sat[2].clip | rs_sat.clip;
	end

	logic             v_s3;
	sq_side_t         side_s3;
	logic [RAD_W-1:0] rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side3;
		rad_s3  <= rad3;
	end

	// ---- square root
	logic              v_sq;
	sq_side_t          side_sq;
	logic [ROOT_W-1:0] root_sq;

	v3alu_sqrt #(.side_t(sq_side_t)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_side   (side_s3),
		.radicand  (rad_s3),
		.out_valid (v_sq),
		.out_side  (side_sq),
		.root      (root_sq)
	);

	// ---- stage 4: divider setup (magnitudes and signs)
	dv_side_t                       side4;
	logic [LANES-1:0][DIV_N_W-1:0]  n4;
	logic [LANES-1:0][DIV_D_W-1:0]  d4;
	sat_t                           norm_sat;
	logic                           is_div4;
	logic                           is_unit4;

	always_comb begin
		is_unit4 = (side_sq.kind == OP_UNIT);
		is_div4  = side_sq.kind inside {OP_EDIV, OP_DIVS, OP_SDIVV};
		side4      = '0;
		side4.kind = side_sq.kind;
		side4.num  = side_sq.num;
		side4.r    = side_sq.r;
		side4.rs   = side_sq.rs;
		side4.sat  = side_sq.sat;
		norm_sat   = sat_fx(WIDE_W'({1'b0, root_sq}));
		if (side_sq.kind == OP_NORM) begin
			side4.rs  = norm_sat.val;
			side4.sat = norm_sat.clip;
		end
		for (int i = 0; i < LANES; i++) begin
			logic [FIELD_W-1:0] nmag;
			logic [FIELD_W-1:0] dmag;
			nmag = side_sq.num[i][FIELD_W-1] ? (~side_sq.num[i] + 1'b1) : side_sq.num[i];
			dmag = side_sq.den[i][FIELD_W-1] ? (~side_sq.den[i] + 1'b1) : side_sq.den[i];
			if (is_unit4) begin
				dmag = root_sq;
			end
			n4[i] = {nmag, {FRAC_BITS{1'b0}}};
			d4[i] = dmag;
			side4.neg[i]   = side_sq.num[i][FIELD_W-1] ^
				(!is_unit4 && side_sq.den[i][FIELD_W-1]);
			side4.dzero[i] = (is_div4 || is_unit4) && (dmag == '0);
		end
	end

	logic                          v_s4;
	dv_side_t                      side_s4;
	logic [LANES-1:0][DIV_N_W-1:0] n_s4;
	logic [LANES-1:0][DIV_D_W-1:0] d_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_sq;
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side4;
		n_s4    <= n4;
		d_s4    <= d4;
	end

	// ---- division
	logic                          v_dv;
	dv_side_t                      side_dv;
	logic [LANES-1:0][DIV_N_W-1:0] q_dv;

	v3alu_div #(.side_t(dv_side_t)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_side   (side_s4),
		.dividend  (n_s4),
		.divisor   (d_s4),
		.out_valid (v_dv),
		.out_side  (side_dv),
		.quotient  (q_dv)
	);

	// ---- final select: sign, divide-by-zero, saturation
	rsp_t rsp5;
	fx_t  rv [LANES];
	logic dz5;
	logic sat5;
	logic is_div5;

	always_comb begin
		is_div5 = side_dv.kind inside {OP_EDIV, OP_DIVS, OP_SDIVV};
		dz5  = 1'b0;
		sat5 = side_dv.sat;
		for (int i = 0; i < LANES; i++) begin
			logic signed [WIDE_W-1:0] qs;
			sat_t                     qsat;
			qs   = WIDE_W'({1'b0, q_dv[i]});
			qs   = side_dv.neg[i] ? -qs : qs;
			qsat = sat_fx(qs);
			rv[i] = side_dv.r[i];
			if (is_div5) begin
				if (side_dv.dzero[i]) begin
					rv[i] = side_dv.num[i][FIELD_W-1] ? FX_MIN[FIELD_W-1:0] :
						FX_MAX[FIELD_W-1:0];
					dz5  = 1'b1;
					sat5 = 1'b1;
				end else begin
					rv[i] = qsat.val;
					sat5  = sat5 | qsat.clip;
				end
			end else if (side_dv.kind == OP_UNIT) begin
				if (side_dv.dzero[i]) begin
					// zero vector passes through
					rv[i] = side_dv.num[i];
				end else begin
					rv[i] = qsat.val;
					sat5  = sat5 | qsat.clip;
				end
			end
		end
		rsp5.res_x      = rv[0];
		rsp5.res_y      = rv[1];
		rsp5.res_z      = rv[2];
		rsp5.res_scalar = side_dv.rs;
		rsp5.saturated  = sat5;
		rsp5.div_zero   = dz5;
	end

	logic [3:0] kind_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		result  <= rsp5;
		kind_s5 <= side_dv.kind;
	end

	// ---- checks
	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("result word missing at fixed latency");

	a_dz_implies_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.div_zero |-> result.saturated)
		else $error("div_zero without saturated");

	a_scalar_only_dot_norm: assert property (@(posedge clk) disable iff (!arst_n)
		done && kind_s5 != OP_DOT && kind_s5 != OP_NORM |-> result.res_scalar == '0)
		else $error("res_scalar nonzero for vector operation");

	a_dz_only_div: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.div_zero |->
			(kind_s5 == OP_EDIV || kind_s5 == OP_DIVS || kind_s5 == OP_SDIVV))
		else $error("div_zero on non-divide operation");

endmodule

`default_nettype wire

// ===== verif/v3alu_checker.sv =====
// ----------------------------------------------------------------------------
// v3alu_checker: result predictor and scoreboard for the vector ALU
// Watches command words taken and result words strobed, predicts each result
// and compares it field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module v3alu_checker
	import v3alu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic busy,
	input  wire cmd_t operands,
	input  wire logic done,
	input  wire rsp_t result,
	output int        fail_count,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [127:0] big_t;

	localparam big_t ONE  = big_t'(1) <<< FRAC_BITS;
	localparam big_t TOP  = (big_t'(1) <<< (WORD_BITS - 1)) - 1;
	localparam big_t BOT  = -TOP - 1;

	rsp_t expected_q[$];

	// floor division by 2^FRAC_BITS (arithmetic shift floors)
	function automatic big_t q_floor(big_t v);
		return v >>> FRAC_BITS;
	endfunction

	// truncating division toward zero
	function automatic big_t q_div(big_t n, big_t d, inout logic dz);
		big_t mn, md, q;
		if (d == 0) begin
			dz = 1'b1;
			return (n >= 0) ? TOP + 1 : BOT - 1;
		end
		mn = (n < 0) ? -n : n;
		md = (d < 0) ? -d : d;
		q  = (mn * ONE) / md;
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic big_t int_sqrt(big_t s);
		big_t lo, hi, mid;
		lo = 0;
		hi = big_t'(1) <<< 34;
		while (lo < hi) begin
			mid = (lo + hi + 1) >>> 1;
			if (mid * mid <= s) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic fx_t clip(big_t v, inout logic f);
		if (v > TOP) begin f = 1'b1; return fx_t'(TOP); end
		if (v < BOT) begin f = 1'b1; return fx_t'(BOT); end
		return fx_t'(v);
	endfunction

	function automatic rsp_t predict_result(cmd_t c);
		big_t a[3], b[3], r[3], s, rs, mag;
		logic sf, dz;
		rsp_t o;
		a = '{big_t'(c.a_x), big_t'(c.a_y), big_t'(c.a_z)};
		b = '{big_t'(c.b_x), big_t'(c.b_y), big_t'(c.b_z)};
		s = big_t'(c.scalar);
		r = '{0, 0, 0};
		rs = 0;
		sf = 1'b0;
		dz = 1'b0;
		case (c.kind)
			OP_ADD:   for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
			OP_SUB:   for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
			OP_EMUL:  for (int i = 0; i < 3; i++) r[i] = q_floor(a[i] * b[i]);
			OP_EDIV:  for (int i = 0; i < 3; i++) r[i] = q_div(a[i], b[i], dz);
			OP_ADDS:  for (int i = 0; i < 3; i++) r[i] = a[i] + s;
			OP_SUBS:  for (int i = 0; i < 3; i++) r[i] = a[i] - s;
			OP_MULS:  for (int i = 0; i < 3; i++) r[i] = q_floor(a[i] * s);
			OP_DIVS:  for (int i = 0; i < 3; i++) r[i] = q_div(a[i], s, dz);
			OP_SMINV: for (int i = 0; i < 3; i++) r[i] = s - b[i];
			OP_SDIVV: for (int i = 0; i < 3; i++) r[i] = q_div(s, b[i], dz);
			OP_NEG:   for (int i = 0; i < 3; i++) r[i] = -b[i];
			OP_CROSS: begin
				r[0] = q_floor(a[1] * b[2] - a[2] * b[1]);
				r[1] = q_floor(a[2] * b[0] - a[0] * b[2]);
				r[2] = q_floor(a[0] * b[1] - a[1] * b[0]);
			end
			OP_DOT:  rs = q_floor(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
			OP_NORM: rs = int_sqrt(b[0] * b[0] + b[1] * b[1] + b[2] * b[2]);
			OP_UNIT: begin
				mag = int_sqrt(b[0] * b[0] + b[1] * b[1] + b[2] * b[2]);
				for (int i = 0; i < 3; i++)
					r[i] = (mag > 0) ? q_div(b[i], mag, dz) : b[i];
			end
			default: ;
		endcase
		o.res_x      = clip(r[0], sf);
		o.res_y      = clip(r[1], sf);
		o.res_z      = clip(r[2], sf);
		o.res_scalar = clip(rs, sf);
		o.saturated  = sf;
		o.div_zero   = dz;
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
	end

	assign pending = expected_q.size();

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && start && !busy)
			expected_q.push_back(predict_result(operands));
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected word", result, 0);
			end else begin
				e = expected_q.pop_front();
				if (result.res_x !== e.res_x)
					report_mismatch("res_x", result.res_x, e.res_x);
				if (result.res_y !== e.res_y)
					report_mismatch("res_y", result.res_y, e.res_y);
				if (result.res_z !== e.res_z)
					report_mismatch("res_z", result.res_z, e.res_z);
				if (result.res_scalar !== e.res_scalar)
					report_mismatch("res_scalar", result.res_scalar, e.res_scalar);
				if (result.saturated !== e.saturated)
					report_mismatch("saturated", result.saturated, e.saturated);
				if (result.div_zero !== e.div_zero)
					report_mismatch("div_zero", result.div_zero, e.div_zero);
			end
		end
	end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: regression bench for the 3-vector fixed-point ALU
// Directed corner words, then random words in idle-pattern phases; the
// checker predicts and scores every result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import v3alu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// extra clocks run after the checker queue empties, before the verdict
	localparam int DRAIN = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t operands = '0;
	logic busy;
	logic done;
	rsp_t result;
	int   fail_count;
	int   pending;
	int   idle_pct;

	always #1 clk = ~clk;

	vector3_fixed_point_alu dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operands(operands), .done(done), .result(result)
	);

	v3alu_checker scoreboard (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operands(operands), .done(done), .result(result),
		.fail_count(fail_count), .pending(pending)
	);

	// random field with frequent extremes, zeros and small Q16.16 values
	function automatic fx_t rand_field();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3, 4: return fx_t'($signed($urandom_range(0, 32'h0003ffff)) - 32'sh20000);
			5: return fx_t'($signed($urandom_range(0, 32'h0fffffff)) - 32'sh08000000);
			default: return fx_t'($urandom);
		endcase
	endfunction

	// drive one word; hold start until the edge where busy is low
	task automatic send_word(cmd_t w);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		operands <= w;
		start    <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic cmd_t make_word(logic [3:0] k, fx_t ax, fx_t ay, fx_t az,
			fx_t bx, fx_t by, fx_t bz, fx_t s);
		cmd_t w;
		w.kind = k; w.a_x = ax; w.a_y = ay; w.a_z = az;
		w.b_x = bx; w.b_y = by; w.b_z = bz; w.scalar = s;
		return w;
	endfunction

	initial begin
		cmd_t w;
		int   waited;
		idle_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every op at the extremes, divide by zero, zero-vector unit,
		// huge unit, unused code
		for (int k = 0; k < 15; k++)
			send_word(make_word(k[3:0], 32'sh7fffffff, 32'sh80000000, 32'sh10000,
				32'sh7fffffff, 32'sh80000000, -32'sh18000, 32'sh80000000));
		send_word(make_word(OP_EDIV, 32'sh10000, -32'sh10000, 0, 0, 0, 0, 0));
		send_word(make_word(OP_DIVS, 32'sh10000, -32'sh10000, 0, 1, 1, 1, 0));
		send_word(make_word(OP_SDIVV, 0, 0, 0, 0, 32'sh20000, 0, -5));
		send_word(make_word(OP_UNIT, 1, 2, 3, 0, 0, 0, 0));
		send_word(make_word(OP_UNIT, 0, 0, 0, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 0));
		send_word(make_word(OP_NORM, 0, 0, 0, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 0));
		send_word(make_word(4'd15, -1, -1, -1, -1, -1, -1, -1));
		send_word(make_word(OP_EMUL, -1, 1, -32'sh8000, 1, -1, 32'sh8000, 0));
		send_word('0);

		// random phases: no idling, heavy idling, moderate idling, then no idling again
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 0) ? 0 : (ph == 1) ? 48 : (ph == 2) ? 23 : 0;
			repeat (110) begin
				w.kind   = ($urandom_range(0, 49) == 0) ? 4'd15
					: 4'($urandom_range(0, 14));
				w.a_x = rand_field(); w.a_y = rand_field(); w.a_z = rand_field();
				w.b_x = rand_field(); w.b_y = rand_field(); w.b_z = rand_field();
				w.scalar = rand_field();
				send_word(w);
			end
		end
		start <= 1'b0;

		waited = 0;
		while (pending != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#200000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
